// ----- src/oprs_pkg.sv -----
// Shared types, constants and the microcode table of the OLED page refresh streamer.
package oprs_pkg;

    localparam int SCREEN_COLS = 128;
    localparam int SCREEN_ROWS = 64;
    localparam int STORE_BYTES = (SCREEN_COLS * SCREEN_ROWS) / 8;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(SCREEN_COLS);
    localparam int ROW_BYTES   = SCREEN_COLS / 8;
    // wide enough for any page/row/column address, with room to spot overflow
    localparam int GADDR_W     = 12;

    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LO   = 8'h00;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] CMD_CONTRAST = 8'h81;
    localparam logic [7:0] PIXEL_MASK   = 8'h01;

    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_RENDER   = 2'd1;
    localparam logic [1:0] REQ_CONTRAST = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] store_index;
        logic [7:0] store_byte;
        logic [2:0] first_page;
        logic [2:0] final_page;
        logic [7:0] contrast_value;
    } req_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       data_mode;
        logic       last_byte;
        logic       busy_res;
        logic       rejected;
    } res_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CON_CMD  = 3'd1,
        PH_CON_VAL  = 3'd2,
        PH_PAGE_CMD = 3'd3,
        PH_COL_LO   = 3'd4,
        PH_COL_HI   = 3'd5,
        PH_DATA     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        U_CLEAR,
        U_FETCH,
        U_DECODE,
        U_REJECT,
        U_WRITE,
        U_RENDER,
        U_CONTRAST,
        U_NOP,
        U_CON_CMD,
        U_CON_VAL,
        U_PAGE_CMD,
        U_COL_LO,
        U_COL_HI,
        U_GATHER,
        U_DATA,
        U_EMIT
    } ustep_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_REJECT,
        OP_WRITE,
        OP_RENDER,
        OP_CONTRAST,
        OP_BLANK,
        OP_CON_CMD,
        OP_CON_VAL,
        OP_PAGE_CMD,
        OP_COL_LO,
        OP_COL_HI,
        OP_GATHER,
        OP_DATA,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_FIRE,
        C_DISPATCH,
        C_GATHER_DONE,
        C_CLEAR_DONE,
        C_OUT_FREE
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        ustep_t next;
        logic   take_in;
    } uword_t;

    typedef struct packed {
        logic       in_fire;
        logic       out_free;
        logic       gather_last;
        logic       clear_last;
        logic [1:0] req_type;
        phase_t     phase;
    } ustat_t;

    function automatic uword_t ucode(input ustep_t s);
        uword_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, next: U_FETCH, take_in: 1'b0};
        unique case (s)
            U_CLEAR:    w = '{op: OP_CLEAR,    cond: C_CLEAR_DONE,  next: U_FETCH,  take_in: 1'b0};
            U_FETCH:    w = '{op: OP_NONE,     cond: C_IN_FIRE,     next: U_DECODE, take_in: 1'b1};
            U_DECODE:   w = '{op: OP_NONE,     cond: C_DISPATCH,    next: U_FETCH,  take_in: 1'b0};
            U_REJECT:   w = '{op: OP_REJECT,   cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_WRITE:    w = '{op: OP_WRITE,    cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_RENDER:   w = '{op: OP_RENDER,   cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_CONTRAST: w = '{op: OP_CONTRAST, cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_NOP:      w = '{op: OP_BLANK,    cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_CON_CMD:  w = '{op: OP_CON_CMD,  cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_CON_VAL:  w = '{op: OP_CON_VAL,  cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_PAGE_CMD: w = '{op: OP_PAGE_CMD, cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_COL_LO:   w = '{op: OP_COL_LO,   cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_COL_HI:   w = '{op: OP_COL_HI,   cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_GATHER:   w = '{op: OP_GATHER,   cond: C_GATHER_DONE, next: U_DATA,   take_in: 1'b0};
            U_DATA:     w = '{op: OP_DATA,     cond: C_ALWAYS,      next: U_EMIT,   take_in: 1'b0};
            U_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE,    next: U_FETCH,  take_in: 1'b0};
            default:    w = '{op: OP_NONE,     cond: C_ALWAYS,      next: U_FETCH,  take_in: 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ----- src/oprs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module oprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/oprs_useq.sv -----
// Microprogram sequencer: step counter, control store lookup and jump logic.
module oprs_useq
    import oprs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ustat_t stat,
    output uword_t cw
);

    ustep_t upc_reg;
    ustep_t upc_next;
    ustep_t dispatch;

    assign cw = ucode(upc_reg);

    // multi-way branch on request kind, busy and sequencer phase
    always_comb
    begin
        dispatch = U_NOP;
        if (stat.req_type != REQ_TICK)
        begin
            if (stat.phase != PH_IDLE)
            begin
                dispatch = U_REJECT;
            end
            else
            begin
                unique case (stat.req_type)
                    REQ_WRITE:  dispatch = U_WRITE;
                    REQ_RENDER: dispatch = U_RENDER;
                    default:    dispatch = U_CONTRAST;
                endcase
            end
        end
        else
        begin
            unique case (stat.phase)
                PH_CON_CMD:  dispatch = U_CON_CMD;
                PH_CON_VAL:  dispatch = U_CON_VAL;
                PH_PAGE_CMD: dispatch = U_PAGE_CMD;
                PH_COL_LO:   dispatch = U_COL_LO;
                PH_COL_HI:   dispatch = U_COL_HI;
                PH_DATA:     dispatch = U_GATHER;
                default:     dispatch = U_NOP;
            endcase
        end
    end

    always_comb
    begin
        upc_next = upc_reg;
        unique case (cw.cond)
            C_ALWAYS:      upc_next = cw.next;
            C_IN_FIRE:     upc_next = stat.in_fire ? cw.next : upc_reg;
            C_DISPATCH:    upc_next = dispatch;
            C_GATHER_DONE: upc_next = stat.gather_last ? cw.next : upc_reg;
            C_CLEAR_DONE:  upc_next = stat.clear_last ? cw.next : upc_reg;
            C_OUT_FREE:    upc_next = stat.out_free ? cw.next : upc_reg;
            default:       upc_next = U_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- src/oprs_dpath.sv -----
// Datapath: frame store, page/column counters and the column gather unit.
module oprs_dpath
    import oprs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  uop_t   op,
    input  req_t   item,
    output res_t   result,
    output phase_t phase,
    output logic   gather_last,
    output logic   clear_last
);

    phase_t             phase_reg, phase_next;
    logic [2:0]         cur_reg, cur_next;
    logic [2:0]         stop_reg, stop_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [7:0]         con_reg, con_next;
    logic [2:0]         row_reg, row_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [2:0]         rd_row_reg, rd_row_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         acc_reg, acc_next;
    logic [STORE_AW-1:0] clr_reg, clr_next;
    res_t               res_reg, res_next;

    logic [GADDR_W-1:0] gaddr;
    logic               gaddr_ok;
    logic               widx_ok;
    logic [7:0]         rdata;
    logic [7:0]         pix_byte;
    logic               pix;
    logic [7:0]         gathered;
    logic [COL_W:0]     col_inc;
    logic               ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;

    assign gaddr = GADDR_W'({cur_reg, row_reg}) * GADDR_W'(ROW_BYTES)
                 + GADDR_W'(col_reg >> 3);
    assign gaddr_ok = gaddr < GADDR_W'(STORE_BYTES);
    assign widx_ok  = GADDR_W'(item.store_index) < GADDR_W'(STORE_BYTES);

    assign pix_byte = (rdata >> col_reg[2:0]) & PIXEL_MASK;
    assign pix      = pix_byte[0] & rd_ok_reg;
    assign gathered = acc_reg | (8'(pix) << rd_row_reg);
    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);

    assign ram_we    = (op == OP_CLEAR) || ((op == OP_WRITE) && widx_ok);
    assign ram_waddr = (op == OP_CLEAR) ? clr_reg : STORE_AW'(item.store_index);
    assign ram_wdata = (op == OP_CLEAR) ? 8'h00 : item.store_byte;

    oprs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (gaddr[STORE_AW-1:0]),
        .rdata (rdata)
    );

    assign phase       = phase_reg;
    assign gather_last = (row_reg == 3'(7));
    assign clear_last  = (clr_reg == STORE_AW'(STORE_BYTES - 1));

    always_comb
    begin
        result          = res_reg;
        result.busy_res = (phase_reg != PH_IDLE);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        stop_next    = stop_reg;
        col_next     = col_reg;
        con_next     = con_reg;
        row_next     = row_reg;
        rd_pend_next = 1'b0;
        rd_row_next  = rd_row_reg;
        rd_ok_next   = rd_ok_reg;
        acc_next     = rd_pend_reg ? gathered : acc_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;

        case (op)
            OP_CLEAR:
            begin
                clr_next = clr_reg + STORE_AW'(1);
            end
            OP_REJECT:
            begin
                res_next          = '0;
                res_next.rejected = 1'b1;
            end
            OP_WRITE, OP_BLANK:
            begin
                res_next = '0;
            end
            OP_RENDER:
            begin
                res_next = '0;
                if (item.first_page <= item.final_page)
                begin
                    cur_next   = item.first_page;
                    stop_next  = item.final_page;
                    col_next   = '0;
                    phase_next = PH_PAGE_CMD;
                end
            end
            OP_CONTRAST:
            begin
                res_next   = '0;
                con_next   = item.contrast_value;
                phase_next = PH_CON_CMD;
            end
            OP_CON_CMD:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = CMD_CONTRAST;
                phase_next          = PH_CON_VAL;
            end
            OP_CON_VAL:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = con_reg;
                res_next.last_byte  = 1'b1;
                phase_next          = PH_IDLE;
            end
            OP_PAGE_CMD:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = CMD_PAGE | {5'b0, cur_reg};
                phase_next          = PH_COL_LO;
            end
            OP_COL_LO:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = CMD_COL_LO;
                phase_next          = PH_COL_HI;
            end
            OP_COL_HI:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = CMD_COL_HI;
                col_next            = '0;
                phase_next          = PH_DATA;
            end
            OP_GATHER:
            begin
                // issue one row read; the store registers the read data, then its bit is ORed into acc
                rd_pend_next = 1'b1;
                rd_row_next  = row_reg;
                rd_ok_next   = gaddr_ok;
                row_next     = row_reg + 3'(1);
            end
            OP_DATA:
            begin
                res_next            = '0;
                res_next.byte_valid = 1'b1;
                res_next.data_mode  = 1'b1;
                res_next.out_byte   = gathered;
                acc_next            = '0;
                if (col_inc >= (COL_W+1)'(SCREEN_COLS))
                begin
                    col_next = '0;
                    if (cur_reg >= stop_reg)
                    begin
                        res_next.last_byte = 1'b1;
                        phase_next         = PH_IDLE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 3'(1);
                        phase_next = PH_PAGE_CMD;
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cur_reg     <= '0;
            stop_reg    <= '0;
            col_reg     <= '0;
            con_reg     <= '0;
            row_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_row_reg  <= '0;
            rd_ok_reg   <= 1'b0;
            acc_reg     <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            stop_reg    <= stop_next;
            col_reg     <= col_next;
            con_reg     <= con_next;
            row_reg     <= row_next;
            rd_pend_reg <= rd_pend_next;
            rd_row_reg  <= rd_row_next;
            rd_ok_reg   <= rd_ok_next;
            acc_reg     <= acc_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ----- src/oled_page_refresh_streamer.sv -----
// Top level of the OLED page refresh streamer: handshake registers, sequencer and datapath.
//
// Each request transfer yields exactly one result transfer. A microprogram walks
// every request through fetch, decode, one action step and an emit step; a pixel
// data tick has gather steps and a data step in place of the action step. For a
// write, render, contrast or command tick the action step registers the result
// and the emit step copies it into the output register; the next request is taken
// only after the emit step. For a pixel data tick the eight rows of one column are
// read one per cycle from the single read port of the frame store. The emit step
// holds while the previous result has not been taken.
// After reset the frame store is zeroed by a clearing pass over all STORE_BYTES
// bytes (1024 for a 128x64 screen) before the first request is taken. A finished
// result waits in the output register while the next request is already accepted.
module oled_page_refresh_streamer
    import oprs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    uword_t cw;
    ustat_t stat;
    req_t   item_reg;
    res_t   out_reg;
    logic   res_valid_reg, res_valid_next;
    res_t   dp_result;
    phase_t dp_phase;
    logic   dp_gather_last;
    logic   dp_clear_last;
    logic   in_fire;
    logic   out_free;
    logic   emit;

    assign req_ready = cw.take_in;
    assign in_fire   = req_valid && req_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign emit      = (cw.op == OP_EMIT) && out_free;

    always_comb
    begin
        stat.in_fire     = in_fire;
        stat.out_free    = out_free;
        stat.gather_last = dp_gather_last;
        stat.clear_last  = dp_clear_last;
        stat.req_type    = item_reg.req_type;
        stat.phase       = dp_phase;
    end

    oprs_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw)
    );

    oprs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (cw.op),
        .item        (item_reg),
        .result      (dp_result),
        .phase       (dp_phase),
        .gather_last (dp_gather_last),
        .clear_last  (dp_clear_last)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= req;
        end
        if (emit)
        begin
            out_reg <= dp_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = out_reg;

endmodule

// ----- src/oprs_checker.sv -----
// Port-level checker for the OLED page refresh streamer, bound to the top level.
module oprs_checker
    import oprs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // a rejected request never emits a controller byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.rejected && res.byte_valid))
        else $error("rejected result carries a byte");

    // idle results carry no byte contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.byte_valid) |-> (res.out_byte == 8'h00 && !res.data_mode
                                             && !res.last_byte))
        else $error("empty result has nonzero fields");

    // the last byte of a transfer releases busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last_byte) |-> (!res.busy_res && res.byte_valid))
        else $error("last byte without busy release");

    // a pixel byte only appears inside an active render
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.data_mode && !res.last_byte) |-> res.busy_res)
        else $error("data byte outside a render");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind oled_page_refresh_streamer oprs_checker u_oprs_checker (.*);
